// ===== rtl/core/plst_pkg.sv =====
// shared types and constants for the positional list engine
// no dependencies; used by plst_ctrl, plst_dpath and the top level
package plst_pkg;

    // fixed field widths
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // request kinds
    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_GET    = 2'd3
    } t_func;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
        logic shift_start;
        logic shift_step;
        logic get_rd;
        logic get_cap;
        logic out_load;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_func func;
        logic  refuse;
        logic  direct;
        logic  busy;
    } t_dp_stat;

endpackage

// ===== rtl/core/plst_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module plst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/plst_dpath.sv =====
// datapath of the positional list engine: request latch, entry count,
// shift address generation, entry ram and result registers
// depends on plst_pkg and plst_ram
module plst_dpath #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  plst_pkg::t_dp_cmd             i_cmd,
    output plst_pkg::t_dp_stat            o_stat,
    input  plst_pkg::t_func               i_func,
    input  logic [plst_pkg::POS_W-1:0]    i_position,
    input  logic [DATA_WIDTH-1:0]         i_word,
    output logic [DATA_WIDTH-1:0]         o_out_word,
    output plst_pkg::t_status             o_out_status,
    output logic [plst_pkg::COUNT_W-1:0]  o_out_count
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int POS_W   = plst_pkg::POS_W;
    localparam int COUNT_W = plst_pkg::COUNT_W;
    localparam int CMPW    = (CW > POS_W) ? CW : POS_W;

    // latched request
    plst_pkg::t_func        r_func;
    logic [POS_W-1:0]       r_pos;
    logic [DATA_WIDTH-1:0]  r_word;

    // list state and shift control
    logic [CW-1:0]          r_count, n_count;
    logic                   r_rd_act, n_rd_act;
    logic [AW-1:0]          r_rd_addr, n_rd_addr;
    logic [AW-1:0]          r_end;
    logic                   r_wr_pend, n_wr_pend;
    logic [AW-1:0]          r_wr_addr, n_wr_addr;

    // working result and output registers
    plst_pkg::t_status      r_st;
    logic [DATA_WIDTH-1:0]  r_wd;
    plst_pkg::t_status      r_out_status;
    logic [DATA_WIDTH-1:0]  r_out_word;
    logic [COUNT_W-1:0]     r_out_count;

    // ram ports
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [DATA_WIDTH-1:0]  ram_wr_data;
    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [DATA_WIDTH-1:0]  ram_rd_data;

    // decode
    logic [CMPW-1:0]        pos_c;
    logic [CMPW-1:0]        cnt_c;
    logic                   full;
    logic                   grows;
    logic                   out_of_range;
    logic                   is_ins;

    assign pos_c  = CMPW'(r_pos);
    assign cnt_c  = CMPW'(r_count);
    assign full   = (r_count == CW'(DEPTH));
    assign grows  = (r_func == plst_pkg::FUNC_APPEND) || (r_func == plst_pkg::FUNC_INSERT);
    assign is_ins = (r_func == plst_pkg::FUNC_INSERT);

    // position checks per request kind
    always_comb begin
        case (r_func)
            plst_pkg::FUNC_APPEND: out_of_range = 1'b0;
            plst_pkg::FUNC_INSERT: out_of_range = (pos_c > cnt_c);
            default:               out_of_range = (pos_c >= cnt_c);
        endcase
    end

    // status toward controller
    always_comb begin
        o_stat.func   = r_func;
        o_stat.refuse = (grows && full) || out_of_range;
        o_stat.busy   = r_rd_act || r_wr_pend;
        case (r_func)
            plst_pkg::FUNC_APPEND: o_stat.direct = 1'b1;
            plst_pkg::FUNC_INSERT: o_stat.direct = (pos_c == cnt_c);
            plst_pkg::FUNC_DELETE: o_stat.direct = ((pos_c + CMPW'(1)) == cnt_c);
            default:               o_stat.direct = 1'b0;
        endcase
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_pos  <= i_position;
            r_word <= i_word;
        end
    end

    // shift sequencing, count update and ram port muxing
    always_comb begin
        n_count     = r_count;
        n_rd_act    = r_rd_act;
        n_rd_addr   = r_rd_addr;
        n_wr_pend   = r_wr_pend;
        n_wr_addr   = r_wr_addr;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wr_addr;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_rd_addr;

        // start: insert walks down from the tail, delete walks up from pos+1
        if (i_cmd.shift_start) begin
            n_rd_act  = 1'b1;
            n_wr_pend = 1'b0;
            if (is_ins) begin
                n_rd_addr = AW'(r_count - CW'(1));
            end else begin
                n_rd_addr = AW'(r_pos) + AW'(1);
            end
        end

        // one entry moved per cycle: read one ahead, write the word read last cycle
        if (i_cmd.shift_step) begin
            n_wr_pend = r_rd_act;
            if (r_rd_act) begin
                ram_rd_en = 1'b1;
                n_wr_addr = is_ins ? (r_rd_addr + AW'(1)) : (r_rd_addr - AW'(1));
                if (r_rd_addr == r_end) begin
                    n_rd_act = 1'b0;
                end else begin
                    n_rd_addr = is_ins ? (r_rd_addr - AW'(1)) : (r_rd_addr + AW'(1));
                end
            end
            if (r_wr_pend) begin
                ram_wr_en = 1'b1;
            end
        end

        // get read at the requested position
        if (i_cmd.get_rd) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(r_pos);
        end

        // final write of the new word, or count drop for delete
        if (i_cmd.commit) begin
            if (r_func == plst_pkg::FUNC_DELETE) begin
                n_count = r_count - CW'(1);
            end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = (r_func == plst_pkg::FUNC_APPEND) ? AW'(r_count) : AW'(r_pos);
                ram_wr_data = r_word;
                n_count     = r_count + CW'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_act  <= 1'b0;
            r_wr_pend <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_rd_act  <= n_rd_act;
            r_wr_pend <= n_wr_pend;
        end
    end

    // shift address registers
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_wr_addr <= n_wr_addr;
        if (i_cmd.shift_start) begin
            r_end <= is_ins ? AW'(r_pos) : AW'(r_count - CW'(1));
        end
    end

    // working result
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            if (grows && full) begin
                r_st <= plst_pkg::ST_FULL;
            end else if (out_of_range) begin
                r_st <= plst_pkg::ST_RANGE;
            end else begin
                r_st <= plst_pkg::ST_DONE;
            end
            r_wd <= ((r_func == plst_pkg::FUNC_GET) && out_of_range) ? '1 : '0;
        end else if (i_cmd.get_cap) begin
            r_wd <= ram_rd_data;
        end
    end

    // output word, status and count registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_word   <= r_wd;
            r_out_status <= r_st;
            r_out_count  <= COUNT_W'(r_count);
        end
    end

    assign o_out_word   = r_out_word;
    assign o_out_status = r_out_status;
    assign o_out_count  = r_out_count;

    // entry store
    plst_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    // final write never collides with a pending shift write
    a_no_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !r_wr_pend && !r_rd_act)
        else $error("commit during shift");

    // a committed append or insert grows the list by one
    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && grows) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("count did not grow on commit");

endmodule

// ===== rtl/core/plst_ctrl.sv =====
// controller of the positional list engine: request sequencing and
// output word valid; drives datapath commands
// depends on plst_pkg
module plst_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_valid,
    output logic                o_s_ready,
    output logic                o_m_valid,
    input  logic                i_m_ready,
    input  plst_pkg::t_dp_stat  i_stat,
    output plst_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL   = 5'b00010,
        S_SHIFT  = 5'b00100,
        S_READ   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid;
        o_cmd     = '0;
        if (r_m_valid && i_m_ready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_stat.refuse) begin
                    n_state = S_FINISH;
                end else if (i_stat.func == plst_pkg::FUNC_GET) begin
                    o_cmd.get_rd = 1'b1;
                    n_state      = S_READ;
                end else if (i_stat.direct) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_FINISH;
                end else begin
                    o_cmd.shift_start = 1'b1;
                    n_state           = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (!i_stat.busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_READ: begin
                o_cmd.get_cap = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (!r_m_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_m_valid;

    // a finished result waits while the output word is still held
    a_finish_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_m_valid && !i_m_ready) |=> (r_state == S_FINISH))
        else $error("result overwrote a held output word");

    // every accepted request reaches evaluation next
    a_load_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EVAL))
        else $error("request skipped evaluation");

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// top level of the positional list engine
// depends on plst_pkg, plst_ctrl, plst_dpath (which holds plst_ram)
//
// Ordered list of up to DEPTH signed words with an entry count.
// Input stream s_axis: one word per request (append, insert, delete, get).
// Output stream m_axis: one word per request with the read word, the status
// and the entry count after the request.
// One request is worked on at a time. Each request is latched, evaluated and
// ends in a finish step that loads the output register; in between:
//   append, refused request, insert at the tail, delete of the last entry: nothing
//   get: a ram read step
//   insert or delete that moves m entries: a shift phase that moves the m entries
// The move rate is one entry per cycle, set by the single write and single
// read port of the entry ram (read one entry ahead, write it one place over).
// The result sits in an output register; a new request is accepted while it
// waits, and processing stalls only when a second result is ready before the
// receiver takes the first.
// Reset (synchronous, active low) empties the list; the ram needs no clearing
// since only entries below the count are ever read.
module positional_list_engine #(
    parameter int DEPTH      = 256,
    parameter int DATA_WIDTH = 32,
    localparam int IN_TW     = ((DATA_WIDTH + 11 + 7) / 8) * 8,
    localparam int OUT_TW    = ((DATA_WIDTH + 11 + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // func[1:0], position[10:2], word_in[DATA_WIDTH+10:11], zero pad
    input  logic [IN_TW-1:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // word_out[DATA_WIDTH-1:0], status[+1:+0], entry_count[+10:+2], zero pad
    output logic [OUT_TW-1:0] m_axis_tdata
);

    localparam int FUNC_W  = plst_pkg::FUNC_W;
    localparam int POS_W   = plst_pkg::POS_W;

    plst_pkg::t_dp_cmd                 cmd;
    plst_pkg::t_dp_stat                stat;
    plst_pkg::t_func                   in_func;
    logic [POS_W-1:0]                  in_pos;
    logic [DATA_WIDTH-1:0]             in_word;
    logic [DATA_WIDTH-1:0]             out_word;
    plst_pkg::t_status                 out_status;
    logic [plst_pkg::COUNT_W-1:0]      out_count;

    // unpack input word
    assign in_func = plst_pkg::t_func'(s_axis_tdata[FUNC_W-1:0]);
    assign in_pos  = s_axis_tdata[FUNC_W+POS_W-1:FUNC_W];
    assign in_word = s_axis_tdata[FUNC_W+POS_W+DATA_WIDTH-1:FUNC_W+POS_W];

    // pack output word
    assign m_axis_tdata = OUT_TW'({out_count, out_status, out_word});

    plst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    plst_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (in_func),
        .i_position   (in_pos),
        .i_word       (in_word),
        .o_out_word   (out_word),
        .o_out_status (out_status),
        .o_out_count  (out_count)
    );

endmodule
